>>> hw/rtl/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-ascii lookup for the base64 encoder
// no dependencies; imported by every b64e module
package b64e_pkg;

  // ascii code of the '=' padding character
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // group place codes
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // one byte's worth of output characters, as queued between front and back
  typedef struct packed {
    logic [3:0][6:0] chars;   // chars[0] goes out first
    logic [1:0]      cnt_m1;  // number of valid chars minus one
    logic            fin;     // last char of this record ends the message
  } b64e_rec_t;

  // standard alphabet lookup: A-Z a-z 0-9 + /
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

>>> hw/rtl/base64_stream_encoder_unit.sv
// base64_stream_encoder_unit: streaming base64 encoder top level
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// Takes one message byte per input beat (tlast marks the final byte) and sends one
// base64 character per output beat, standard alphabet with '=' padding, tlast on the
// final character of the message. The input side takes a byte every cycle while the
// record queue (QDEPTH entries) has room; the output side sends one character per
// cycle while the receiver is ready. The first and second byte of a group each make
// one character, the third two, and a final byte two to four, with '=' padding where
// its group is short. The first character of a byte reaches the output through the
// record queue and then the single character output register.
module base64_stream_encoder_unit #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // out_last
);
  import b64e_pkg::*;

  b64e_rec_t  push_rec;
  b64e_rec_t  head_rec;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic [6:0] out_char;

  // front: group state and character record build
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .q_full     (q_full),
    .byte_ready (s_tready),
    .push       (push),
    .push_rec   (push_rec)
  );

  // queue between front and back
  b64e_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: character serializer and output register
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_rec   (head_rec),
    .empty      (q_empty),
    .pop        (pop),
    .char_ready (m_tready),
    .char_valid (m_tvalid),
    .out_char   (out_char),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

>>> hw/rtl/b64e_front.sv
// b64e_front: keeps group place and carried bits, turns each byte into a character record
// depends on b64e_pkg
module b64e_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  input  logic             q_full,
  output logic             byte_ready,
  output logic             push,
  output b64e_pkg::b64e_rec_t push_rec
);
  import b64e_pkg::*;

  logic [1:0] group_pos;
  logic [3:0] carry_bits;
  logic [1:0] group_pos_next;
  logic [3:0] carry_bits_next;

  assign byte_ready = !q_full;
  assign push       = byte_valid && !q_full;

  // classify by group place and build the record
  always_comb begin
    push_rec        = '0;
    group_pos_next  = POS_FIRST;
    carry_bits_next = 4'd0;
    case (group_pos)
      POS_SECOND: begin
        push_rec.chars[0] = sextet_char({carry_bits[1:0], data_byte[7:4]});
        if (final_byte) begin
          push_rec.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          push_rec.chars[2] = PAD_CHAR;
          push_rec.cnt_m1   = 2'd2;
        end else begin
          push_rec.cnt_m1 = 2'd0;
          group_pos_next  = POS_THIRD;
          carry_bits_next = data_byte[3:0];
        end
      end
      POS_THIRD: begin
        push_rec.chars[0] = sextet_char({carry_bits, data_byte[7:6]});
        push_rec.chars[1] = sextet_char(data_byte[5:0]);
        push_rec.cnt_m1   = 2'd1;
      end
      default: begin
        // first place, and the unused code treated the same
        push_rec.chars[0] = sextet_char(data_byte[7:2]);
        if (final_byte) begin
          push_rec.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          push_rec.chars[2] = PAD_CHAR;
          push_rec.chars[3] = PAD_CHAR;
          push_rec.cnt_m1   = 2'd3;
        end else begin
          push_rec.cnt_m1 = 2'd0;
          group_pos_next  = POS_SECOND;
          carry_bits_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
    push_rec.fin = final_byte;
  end

  // group state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos  <= POS_FIRST;
      carry_bits <= 4'd0;
    end else if (push) begin
      group_pos  <= group_pos_next;
      carry_bits <= carry_bits_next;
    end
  end

endmodule

>>> hw/rtl/b64e_queue.sv
// b64e_queue: small fifo of character records between front and back
// depends on b64e_pkg
module b64e_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64e_pkg::b64e_rec_t push_rec,
  input  logic                pop,
  output b64e_pkg::b64e_rec_t head_rec,
  output logic                full,
  output logic                empty
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64e_rec_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign head_rec = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/b64e_back.sv
// b64e_back: walks the head record one character per cycle, while char_ready allows, into the output register
// depends on b64e_pkg
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  b64e_pkg::b64e_rec_t head_rec,
  input  logic                empty,
  output logic                pop,
  input  logic                char_ready,
  output logic                char_valid,
  output logic [6:0]          out_char,
  output logic                out_last
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = (!char_valid || char_ready) && !empty;
  assign at_end = (idx == head_rec.cnt_m1);
  assign pop    = load && at_end;

  // character index within the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      char_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head_rec.chars[idx];
      out_last <= head_rec.fin && at_end;
    end
  end

endmodule

>>> bench/b64e_stream_checker.sv
// b64e_stream_checker: watches both beat channels of the base64 encoder, predicts the
// character stream from every accepted byte and compares each accepted output beat
// depends on b64e_pkg for the group place codes and the padding character
module b64e_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  input  logic       m_tlast,   // out_last
  output int         fail_count,
  output int         chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  // standard alphabet, first character in the top byte
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t  enc_chars_q[$];
  logic [1:0] place;       // where the next byte falls in its three-byte group
  logic [3:0] held_bits;   // low bits of the previous byte not yet sent

  function automatic logic [6:0] alphabet_char(input logic [5:0] v);
    logic [7:0] c;
    c = ALPHABET[8*(63 - int'(v)) +: 8];
    return c[6:0];
  endfunction

  task automatic push_char(input logic [6:0] ch, input logic last);
    enc_char_t entry;
    entry.ch   = ch;
    entry.last = last;
    enc_chars_q.insert(enc_chars_q.size(), entry);
  endtask

  // expected characters for one byte, advancing the group place
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (place)
      POS_SECOND: begin
        push_char(alphabet_char({held_bits[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
          push_char(PAD_CHAR, 1'b1);
          place = POS_FIRST;
          held_bits = 4'd0;
        end else begin
          place = POS_THIRD;
          held_bits = b[3:0];
        end
      end
      POS_THIRD: begin
        push_char(alphabet_char({held_bits, b[7:6]}), 1'b0);
        push_char(alphabet_char(b[5:0]), fin);
        place = POS_FIRST;
        held_bits = 4'd0;
      end
      default: begin
        push_char(alphabet_char(b[7:2]), 1'b0);
        if (fin) begin
          push_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
          push_char(PAD_CHAR, 1'b0);
          push_char(PAD_CHAR, 1'b1);
          place = POS_FIRST;
          held_bits = 4'd0;
        end else begin
          place = POS_SECOND;
          held_bits = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    enc_char_t want;
    if (rst) begin
      enc_chars_q.delete();
      place = POS_FIRST;
      held_bits = 4'd0;
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (enc_chars_q.size() == 0) begin
          report_mismatch($sformatf("output beat 0x%02h last %0b with nothing expected",
                                    m_tdata, m_tlast));
        end else begin
          want = enc_chars_q.pop_front();
          if (m_tdata[6:0] !== want.ch) begin
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h", m_tdata[6:0], want.ch));
          end
          if (m_tdata[7] !== 1'b0) begin
            report_mismatch("tdata bit 7 not zero");
          end
          if (m_tlast !== want.last) begin
            report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
          end
        end
      end
    end
    chars_pending = enc_chars_q.size();
  end

endmodule

>>> bench/tb_base64_stream_encoder_unit.sv
// tb_base64_stream_encoder_unit: stimulus, clock, reset and verdict for the base64 encoder
// depends on base64_stream_encoder_unit and b64e_stream_checker
module tb_base64_stream_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BYTES  = 500;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int         fail_count;
  int         chars_pending;
  int         idle_cycles;
  bit         long_hold_req = 1'b0;
  logic [7:0] msg_bytes[$];

  always #6 clk = ~clk;

  base64_stream_encoder_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  b64e_stream_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  // offer one byte, after a random gap unless in burst mode, and wait for its beat
  task automatic send_byte(input logic [7:0] data, input logic last, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input bit burst, inout int bytes_sent);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, burst);
      bytes_sent++;
    end
  endtask

  // stop offering and wait until every expected character has gone out
  task automatic drain_chars();
    s_tvalid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
  endtask

  // sender: directed messages, then random ones
  initial begin
    int bytes_sent;
    int len;
    bit burst;
    bit hold_done;
    bit pause_done;
    bytes_sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // final byte at each group place, alphabet ends, all-ones and all-zeros
    msg_bytes = '{8'h00};
    send_message(1'b0, bytes_sent);
    msg_bytes = '{8'hFF};
    send_message(1'b1, bytes_sent);
    msg_bytes = '{8'hFF, 8'hFF};
    send_message(1'b0, bytes_sent);
    msg_bytes = '{8'h00, 8'h00};
    send_message(1'b1, bytes_sent);
    msg_bytes = '{8'hFB, 8'hEF, 8'hBE};
    send_message(1'b0, bytes_sent);
    msg_bytes = '{8'h00, 8'h10, 8'h83, 8'h10, 8'h51, 8'h87};
    send_message(1'b1, bytes_sent);
    msg_bytes = '{8'h55, 8'hAA, 8'hF8, 8'h07};
    send_message(1'b0, bytes_sent);
    drain_chars();

    // random messages, mostly short
    while (bytes_sent < NUM_BYTES) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      burst = ($urandom_range(0, 3) == 0);
      if (!hold_done && bytes_sent > 150) begin
        // receiver stops for a long stretch while bytes keep coming
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        len = 30;
        burst = 1'b1;
      end
      if (!pause_done && bytes_sent > 320) begin
        pause_done = 1'b1;
        drain_chars();
      end
      msg_bytes.delete();
      repeat (len) msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(0, 255)));
      send_message(burst, bytes_sent);
    end

    drain_chars();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("base64_stream_encoder_unit test passed");
    end else begin
      $display("base64_stream_encoder_unit test failed");
    end
    $finish;
  end

  // receiver: random stalls, fast stretches and one long hold
  initial begin
    int stall;
    bit rx_fast;
    rx_fast = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("base64_stream_encoder_unit test failed");
        $finish;
      end
    end
  end

endmodule
